// ===== sv/dnsqe_pkg.sv =====
`timescale 1ns / 1ps

package dnsqe_pkg;

  // name store capacity default
  localparam int NAME_CAPACITY_DEF = 256;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DNS_PORT   = 2'd0,
    CFG_MAX_LABELS = 2'd1,
    CFG_NAME_CAP   = 2'd2
  } cfg_index_t;

  // configuration reset values
  localparam logic [15:0] DNS_PORT_RST   = 16'd53;
  localparam logic [7:0]  MAX_LABELS_RST = 8'd128;
  localparam logic [15:0] NAME_CAP_RST   = 16'd512;

  // protocol constants
  localparam logic [15:0] ETH_IPV4      = 16'h0800;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [5:0]  MIN_IP_HDR    = 6'd20;
  localparam logic [15:0] UDP_DNS_HDR   = 16'd20;
  localparam logic [7:0]  LEN_FLAG_MASK = 8'hC0;
  localparam logic [7:0]  DOT_CHAR      = 8'h2E;

  // byte offsets within the packet
  localparam logic [15:0] POS_PROTO     = 16'd9;
  localparam logic [15:0] POS_SRC_FIRST = 16'd12;
  localparam logic [15:0] POS_SRC_LAST  = 16'd15;

  // offsets relative to the end of the ip header
  localparam logic [15:0] OFS_SPORT_LO  = 16'd1;
  localparam logic [15:0] OFS_DPORT_HI  = 16'd2;
  localparam logic [15:0] OFS_DPORT_LO  = 16'd3;
  localparam logic [15:0] OFS_ULEN_HI   = 16'd4;
  localparam logic [15:0] OFS_ULEN_LO   = 16'd5;
  localparam logic [15:0] OFS_QDCNT_HI  = 16'd12;
  localparam logic [15:0] OFS_QDCNT_LO  = 16'd13;
  localparam logic [15:0] OFS_REC_MIN   = 16'd19;
  localparam logic [15:0] OFS_NAME      = 16'd20;

  // name decoder phase
  typedef enum logic [3:0] {
    PH_EXPECT = 4'b0001,
    PH_LABEL  = 4'b0010,
    PH_DONE   = 4'b0100,
    PH_FAIL   = 4'b1000
  } phase_t;

  // which results one word produces
  typedef struct packed {
    logic has_char;
    logic has_rec;
  } run_flags_t;

endpackage

// ===== sv/dnsqe_parser.sv =====
`timescale 1ns / 1ps

module dnsqe_parser #(
  parameter int NAME_CAPACITY = dnsqe_pkg::NAME_CAPACITY_DEF,
  localparam int LEN_W = $clog2(NAME_CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  logic [7:0]              data_byte,
  input  logic [15:0]             ether_type,
  input  logic                    end_of_packet,
  input  logic [15:0]             dns_port,
  input  logic [7:0]              max_labels,
  input  logic [15:0]             name_region_cap,
  output dnsqe_pkg::run_flags_t   run_flags,
  output logic [7:0]              run_char,
  output logic [31:0]             run_addr,
  output logic [15:0]             run_port,
  output logic [LEN_W-1:0]        run_len
);

  import dnsqe_pkg::*;

  localparam logic [LEN_W-1:0] CHAR_LIMIT = LEN_W'(NAME_CAPACITY - 1);

  // per packet state
  logic [15:0]      pos, pos_next;
  logic [5:0]       hdr, hdr_next;
  logic             qual, qual_next;
  logic [31:0]      src_addr, src_addr_next;
  logic [15:0]      src_port, src_port_next;
  logic [7:0]       dst_hi, dst_hi_next;
  logic [7:0]       udp_hi, udp_hi_next;
  logic [7:0]       qd_hi, qd_hi_next;
  logic [15:0]      nbl, nbl_next;
  logic [5:0]       lbl, lbl_next;
  logic [7:0]       ld, ld_next;
  logic [LEN_W-1:0] cw, cw_next;
  logic [LEN_W-1:0] ltz, ltz_next;
  phase_t           phase, phase_next;

  // working values
  logic [5:0]  h;
  logic [15:0] hx;
  logic [15:0] dst_full;
  logic [15:0] udp_full;
  logic [15:0] qd_full;
  logic        put_req;
  logic        put_fail;
  logic        start_label;
  logic [7:0]  put_c;

  // next state and results for one word
  always_comb begin
    pos_next      = pos;
    hdr_next      = hdr;
    qual_next     = qual;
    src_addr_next = src_addr;
    src_port_next = src_port;
    dst_hi_next   = dst_hi;
    udp_hi_next   = udp_hi;
    qd_hi_next    = qd_hi;
    nbl_next      = nbl;
    lbl_next      = lbl;
    ld_next       = ld;
    cw_next       = cw;
    ltz_next      = ltz;
    phase_next    = phase;
    run_flags     = '0;
    run_char      = '0;
    run_addr      = '0;
    run_port      = '0;
    run_len       = '0;
    put_req       = 1'b0;
    put_fail      = 1'b0;
    start_label   = 1'b0;
    put_c         = data_byte;

    h        = (pos == 16'd0) ? {data_byte[3:0], 2'b00} : hdr;
    hx       = {10'd0, h};
    dst_full = {dst_hi, data_byte};
    udp_full = {udp_hi, data_byte};
    qd_full  = {qd_hi, data_byte};

    if (pos == 16'd0) begin
      hdr_next  = h;
      qual_next = (ether_type == ETH_IPV4) && (h >= MIN_IP_HDR);
    end else if (qual) begin
      if (pos == POS_PROTO) begin
        if (data_byte != PROTO_UDP) qual_next = 1'b0;
      end else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
        src_addr_next = {src_addr[23:0], data_byte};
      end else if (pos == hx || pos == hx + OFS_SPORT_LO) begin
        src_port_next = {src_port[7:0], data_byte};
      end else if (pos == hx + OFS_DPORT_HI) begin
        dst_hi_next = data_byte;
      end else if (pos == hx + OFS_DPORT_LO) begin
        if (src_port != dns_port && dst_full != dns_port) qual_next = 1'b0;
      end else if (pos == hx + OFS_ULEN_HI) begin
        udp_hi_next = data_byte;
      end else if (pos == hx + OFS_ULEN_LO) begin
        // name bound from the udp length, clipped to the cap
        if (udp_full >= UDP_DNS_HDR && (udp_full - UDP_DNS_HDR) < name_region_cap)
          nbl_next = udp_full - UDP_DNS_HDR;
        else
          nbl_next = name_region_cap;
      end else if (pos == hx + OFS_QDCNT_HI) begin
        qd_hi_next = data_byte;
      end else if (pos == hx + OFS_QDCNT_LO) begin
        if (qd_full == 16'd0) qual_next = 1'b0;
      end else if (pos >= hx + OFS_NAME) begin
        // name decoder
        unique case (phase)
          PH_EXPECT: begin
            if (nbl == 16'd0 || ld >= max_labels) begin
              phase_next = PH_DONE;
            end else begin
              nbl_next = nbl - 16'd1;
              if (data_byte == 8'd0) begin
                phase_next = PH_DONE;
              end else if ((data_byte & LEN_FLAG_MASK) != 8'd0 ||
                           {8'd0, data_byte} > nbl - 16'd1) begin
                phase_next = PH_FAIL;
              end else begin
                put_c       = DOT_CHAR;
                put_req     = (cw != '0);
                start_label = 1'b1;
              end
            end
          end
          PH_LABEL: begin
            if (nbl != 16'd0) nbl_next = nbl - 16'd1;
            put_req = 1'b1;
          end
          default: ;
        endcase

        // emit a character unless the name store is full
        put_fail = put_req && (cw >= CHAR_LIMIT);
        if (put_req && !put_fail) begin
          run_flags.has_char = 1'b1;
          run_char           = put_c;
          cw_next            = cw + 1'b1;
          if (ltz == cw && put_c != 8'd0) ltz_next = ltz + 1'b1;
        end

        if (put_fail) begin
          phase_next = PH_FAIL;
        end else if (start_label) begin
          lbl_next   = data_byte[5:0];
          phase_next = PH_LABEL;
        end else if (phase == PH_LABEL) begin
          lbl_next = lbl - 6'd1;
          if (lbl == 6'd1) begin
            ld_next    = ld + 8'd1;
            phase_next = PH_EXPECT;
          end
        end
      end
    end

    // saturating position
    if (pos != 16'hFFFF) pos_next = pos + 16'd1;

    // summary record and clear at packet end
    if (end_of_packet) begin
      if (qual_next && pos >= hx + OFS_REC_MIN) begin
        run_flags.has_rec = 1'b1;
        run_addr          = src_addr_next;
        run_port          = src_port_next;
        if (phase_next == PH_EXPECT || phase_next == PH_DONE)
          run_len = ltz_next + 1'b1;
      end
      pos_next      = '0;
      hdr_next      = '0;
      qual_next     = 1'b0;
      src_addr_next = '0;
      src_port_next = '0;
      dst_hi_next   = '0;
      udp_hi_next   = '0;
      qd_hi_next    = '0;
      nbl_next      = '0;
      lbl_next      = '0;
      ld_next       = '0;
      cw_next       = '0;
      ltz_next      = '0;
      phase_next    = PH_EXPECT;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      hdr      <= '0;
      qual     <= 1'b0;
      src_addr <= '0;
      src_port <= '0;
      dst_hi   <= '0;
      udp_hi   <= '0;
      qd_hi    <= '0;
      nbl      <= '0;
      lbl      <= '0;
      ld       <= '0;
      cw       <= '0;
      ltz      <= '0;
      phase    <= PH_EXPECT;
    end else if (in_fire) begin
      pos      <= pos_next;
      hdr      <= hdr_next;
      qual     <= qual_next;
      src_addr <= src_addr_next;
      src_port <= src_port_next;
      dst_hi   <= dst_hi_next;
      udp_hi   <= udp_hi_next;
      qd_hi    <= qd_hi_next;
      nbl      <= nbl_next;
      lbl      <= lbl_next;
      ld       <= ld_next;
      cw       <= cw_next;
      ltz      <= ltz_next;
      phase    <= phase_next;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst) cw <= CHAR_LIMIT)
    else $error("character count beyond name capacity");
  assert property (@(posedge clk) disable iff (rst) ltz <= cw)
    else $error("length to zero exceeds characters written");
  assert property (@(posedge clk) disable iff (rst) (phase == PH_LABEL) |-> (lbl != 6'd0))
    else $error("label phase with no label bytes left");

endmodule

// ===== sv/dnsqe_out_queue.sv =====
`timescale 1ns / 1ps

module dnsqe_out_queue #(
  parameter int LEN_W = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dnsqe_pkg::run_flags_t push_flags,
  input  logic [7:0]            push_char,
  input  logic [31:0]           push_addr,
  input  logic [15:0]           push_port,
  input  logic [LEN_W-1:0]      push_len,
  output logic                  space_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  item_kind,
  output logic [7:0]            name_char,
  output logic [31:0]           source_address,
  output logic [15:0]           source_port,
  output logic [LEN_W-1:0]      name_length,
  output logic                  last_of_run
);

  import dnsqe_pkg::*;

  // two entry queue of runs
  run_flags_t       q_flags [2];
  logic [7:0]       q_char  [2];
  logic [31:0]      q_addr  [2];
  logic [15:0]      q_port  [2];
  logic [LEN_W-1:0] q_len   [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             part;

  run_flags_t head;
  logic       show_char;
  logic       out_fire;
  logic       pop;

  // head of queue to the output word
  always_comb begin
    head           = q_flags[rd_ptr];
    show_char      = head.has_char && !part;
    out_valid      = (count != 2'd0);
    space_ok       = (count != 2'd2);
    item_kind      = !show_char;
    name_char      = show_char ? q_char[rd_ptr] : 8'd0;
    source_address = show_char ? 32'd0 : q_addr[rd_ptr];
    source_port    = show_char ? 16'd0 : q_port[rd_ptr];
    name_length    = show_char ? '0 : q_len[rd_ptr];
    last_of_run    = show_char ? !head.has_rec : 1'b1;
    out_fire       = out_valid && out_ready;
    pop            = out_fire && last_of_run;
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_flags[wr_ptr] <= push_flags;
      q_char[wr_ptr]  <= push_char;
      q_addr[wr_ptr]  <= push_addr;
      q_port[wr_ptr]  <= push_port;
      q_len[wr_ptr]   <= push_len;
    end
  end

  // pointers, fill count and part of run shown
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      part   <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) begin
        rd_ptr <= !rd_ptr;
        part   <= 1'b0;
      end else if (out_fire) begin
        part <= 1'b1;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst) push |-> (count != 2'd2))
    else $error("run pushed into a full queue");
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst) part |-> (count != 2'd0))
    else $error("second part of a run with the queue empty");

endmodule

// ===== sv/dns_question_name_extractor.sv =====
`timescale 1ns / 1ps
// a word's results are registered in the output queue and shown from there
// throughput: one packet byte per cycle while the output queue has space; an end of packet
//   byte that also gives a name character is shown as the character and then the record
// reset: synchronous, clears packet state and output queue, configuration returns to
//   port 53, 128 labels and a 512 byte name region

module dns_question_name_extractor #(
  parameter int NAME_CAPACITY = dnsqe_pkg::NAME_CAPACITY_DEF,
  localparam int LEN_W = $clog2(NAME_CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic [15:0]           ether_type,
  input  logic                  end_of_packet,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  item_kind,
  output logic [7:0]            name_char,
  output logic [31:0]           source_address,
  output logic [15:0]           source_port,
  output logic [LEN_W-1:0]      name_length,
  output logic                  last_of_run,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  dnsqe_pkg::cfg_index_t cfg_index,
  input  logic [15:0]           cfg_data
);

  import dnsqe_pkg::*;

  logic [15:0]      dns_port;
  logic [7:0]       max_labels;
  logic [15:0]      name_region_cap;
  logic             in_fire;
  logic             space_ok;
  run_flags_t       run_flags;
  logic [7:0]       run_char;
  logic [31:0]      run_addr;
  logic [15:0]      run_port;
  logic [LEN_W-1:0] run_len;

  assign cfg_ready = 1'b1;
  assign in_ready  = space_ok;
  assign in_fire   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dns_port        <= DNS_PORT_RST;
      max_labels      <= MAX_LABELS_RST;
      name_region_cap <= NAME_CAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DNS_PORT:   dns_port        <= cfg_data;
        CFG_MAX_LABELS: max_labels      <= cfg_data[7:0];
        CFG_NAME_CAP:   name_region_cap <= cfg_data;
        default: ;
      endcase
    end
  end

  // header parse and name decode
  dnsqe_parser #(
    .NAME_CAPACITY (NAME_CAPACITY)
  ) u_parser (
    .clk             (clk),
    .rst             (rst),
    .in_fire         (in_fire),
    .data_byte       (data_byte),
    .ether_type      (ether_type),
    .end_of_packet   (end_of_packet),
    .dns_port        (dns_port),
    .max_labels      (max_labels),
    .name_region_cap (name_region_cap),
    .run_flags       (run_flags),
    .run_char        (run_char),
    .run_addr        (run_addr),
    .run_port        (run_port),
    .run_len         (run_len)
  );

  // result queue and serialiser
  dnsqe_out_queue #(
    .LEN_W (LEN_W)
  ) u_out_queue (
    .clk            (clk),
    .rst            (rst),
    .push           (in_fire && (run_flags.has_char || run_flags.has_rec)),
    .push_flags     (run_flags),
    .push_char      (run_char),
    .push_addr      (run_addr),
    .push_port      (run_port),
    .push_len       (run_len),
    .space_ok       (space_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .item_kind      (item_kind),
    .name_char      (name_char),
    .source_address (source_address),
    .source_port    (source_port),
    .name_length    (name_length),
    .last_of_run    (last_of_run)
  );

endmodule
